@@ rtl/fpalu_pkg.sv @@
package fpalu_pkg;

    localparam logic [3:0] FN_ADD  = 4'd0;
    localparam logic [3:0] FN_SUB  = 4'd1;
    localparam logic [3:0] FN_MUL  = 4'd2;
    localparam logic [3:0] FN_DIV  = 4'd3;
    localparam logic [3:0] FN_GT   = 4'd4;
    localparam logic [3:0] FN_LT   = 4'd5;
    localparam logic [3:0] FN_GE   = 4'd6;
    localparam logic [3:0] FN_LE   = 4'd7;
    localparam logic [3:0] FN_EQ   = 4'd8;
    localparam logic [3:0] FN_NE   = 4'd9;
    localparam logic [3:0] FN_MIN  = 4'd10;
    localparam logic [3:0] FN_MAX  = 4'd11;
    localparam logic [3:0] FN_FINT = 4'd12;
    localparam logic [3:0] FN_TINT = 4'd13;
    localparam logic [3:0] FN_INC  = 4'd14;
    localparam logic [3:0] FN_DEC  = 4'd15;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_DIV0  = 2'd2;

    typedef struct packed {
        logic [3:0]         func;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result;
        logic               flag;
        logic [1:0]         status;
    } t_out;

endpackage

@@ rtl/fpalu_div.sv @@
// Restoring divider on magnitudes, one quotient bit per stage.
module fpalu_div #(
    parameter int unsigned NW = 40
) (
    input  logic          i_clk,
    input  logic          i_adv,
    input  logic [NW-1:0] i_num,
    input  logic [31:0]   i_den,
    output logic [NW-1:0] o_quo
);
    logic [NW-1:0] r_q   [NW+1];
    logic [32:0]   r_rem [NW+1];
    logic [31:0]   r_den [NW+1];

    always_comb begin
        r_q[0]   = i_num;
        r_rem[0] = '0;
        r_den[0] = i_den;
    end

    for (genvar s = 0; s < NW; s++) begin : g_st
        logic [33:0] t_sh;
        logic [33:0] t_df;
        always_comb begin
            t_sh = {r_rem[s][32:0], r_q[s][NW-1]};
            t_df = t_sh - {2'b00, r_den[s]};
        end
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_den[s+1] <= r_den[s];
                if (!t_df[33]) begin
                    r_rem[s+1] <= t_df[32:0];
                    r_q[s+1]   <= {r_q[s][NW-2:0], 1'b1};
                end else begin
                    r_rem[s+1] <= t_sh[32:0];
                    r_q[s+1]   <= {r_q[s][NW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quo = r_q[NW];
endmodule

@@ rtl/fixed_point_alu_unit.sv @@
// Channel | Dir | Handshake            | Payload
// in      | in  | i_valid / o_stall    | i_data  (fpalu_pkg::t_in)
// out     | out | o_valid / i_stall    | o_data  (fpalu_pkg::t_out)
//
// One transaction is taken every cycle while the output is not stalled.
// Depth is set by the divider, which resolves one quotient bit per stage.
// Other operations ride along in a delay line beside the divider.
// Reset clears all valid bits; payload registers are not reset.
// A stall at a valid output freezes the whole pipe; input stall follows it, so
// nothing is dropped or repeated.
module fixed_point_alu_unit #(
    parameter int unsigned FRAC_W = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  fpalu_pkg::t_in  i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output fpalu_pkg::t_out o_data
);
    localparam int unsigned NW  = 32 + FRAC_W;
    localparam int unsigned LAT = NW + 3;

    logic adv;
    logic [LAT-1:0] r_vld;
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Stage 1: register operands and the 64-bit product.
    fpalu_pkg::t_in     r1_in;
    logic signed [63:0] r1_prod;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_in   <= i_data;
            r1_prod <= i_data.operand_a * i_data.operand_b;
        end
    end

    // Stage 2: compute every non-divide outcome, and divider operands.
    fpalu_pkg::t_out n2_out, r2_out;
    logic            r2_div, r2_neg;
    logic [NW-1:0]   r2_num;
    logic [31:0]     r2_den;
    logic signed [31:0] a, b;
    logic signed [63:0] prod_sh;
    logic [NW-1:0]   num_mag;
    always_comb begin
        a = r1_in.operand_a;
        b = r1_in.operand_b;
        prod_sh = r1_prod >>> FRAC_W;
        num_mag = {{FRAC_W{1'b0}}, (a[31] ? 32'(-a) : 32'(a))} << FRAC_W;
        n2_out = '0;
        case (r1_in.func)
            fpalu_pkg::FN_ADD: n2_out.result = a + b;
            fpalu_pkg::FN_SUB: n2_out.result = a - b;
            fpalu_pkg::FN_MUL: n2_out.result = prod_sh[31:0];
            fpalu_pkg::FN_DIV: if (b == 0) n2_out.status = fpalu_pkg::ST_DIV0;
            fpalu_pkg::FN_GT:  n2_out.flag = a > b;
            fpalu_pkg::FN_LT:  n2_out.flag = a < b;
            fpalu_pkg::FN_GE:  n2_out.flag = a >= b;
            fpalu_pkg::FN_LE:  n2_out.flag = a <= b;
            fpalu_pkg::FN_EQ:  n2_out.flag = a == b;
            fpalu_pkg::FN_NE:  n2_out.flag = a != b;
            fpalu_pkg::FN_MIN: n2_out.result = (a > b) ? b : a;
            fpalu_pkg::FN_MAX: n2_out.result = (a < b) ? b : a;
            fpalu_pkg::FN_FINT: begin
                // In range when the top FRAC_W+1 bits are all sign.
                if ((a >>> (31 - FRAC_W)) != 0 && (a >>> (31 - FRAC_W)) != -1)
                    n2_out.status = fpalu_pkg::ST_RANGE;
                else
                    n2_out.result = a <<< FRAC_W;
            end
            fpalu_pkg::FN_TINT: n2_out.result = a >>> FRAC_W;
            fpalu_pkg::FN_INC:  n2_out.result = a + 32'sd1;
            default:            n2_out.result = a - 32'sd1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_out <= n2_out;
            r2_div <= (r1_in.func == fpalu_pkg::FN_DIV) && (b != 0);
            r2_neg <= a[31] ^ b[31];
            r2_num <= num_mag;
            r2_den <= b[31] ? 32'(-b) : 32'(b);
        end
    end

    // Divider stages; side data rides a matching delay line.
    logic [NW-1:0] quo;
    fpalu_div #(.NW(NW)) u_div (
        .i_clk  (i_clk),
        .i_adv  (adv),
        .i_num  (r2_num),
        .i_den  (r2_den),
        .o_quo  (quo)
    );

    fpalu_pkg::t_out r_dl_out [NW+1];
    logic            r_dl_div [NW+1];
    logic            r_dl_neg [NW+1];
    always_comb begin
        r_dl_out[0] = r2_out;
        r_dl_div[0] = r2_div;
        r_dl_neg[0] = r2_neg;
    end
    for (genvar s = 0; s < NW; s++) begin : g_dl
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dl_out[s+1] <= r_dl_out[s];
                r_dl_div[s+1] <= r_dl_div[s];
                r_dl_neg[s+1] <= r_dl_neg[s];
            end
        end
    end

    // Final stage: apply quotient sign and select.
    logic [31:0] q32;
    fpalu_pkg::t_out n_out;
    assign q32 = quo[31:0];
    always_comb begin
        n_out = r_dl_out[NW];
        if (r_dl_div[NW])
            n_out.result = r_dl_neg[NW] ? -q32 : q32;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_data <= n_out;
        end
    end

    a_flag_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.flag |-> o_data.result == 0 && o_data.status == fpalu_pkg::ST_OK)
        else $error("flag set with nonzero result");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output changed under stall");
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output");
endmodule

@@ test/fixed_point_alu_unit_tb.sv @@
module fixed_point_alu_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAC = 8;
    localparam int unsigned LATENCY = FRAC + 35;
    localparam longint CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall;
    logic o_valid;
    fpalu_pkg::t_in  i_data = '0;
    fpalu_pkg::t_out o_data;

    fixed_point_alu_unit #(.FRAC_W(FRAC)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    fpalu_pkg::t_out alu_expected_q[$];
    int     mismatch_cnt = 0;
    longint cycle_cnt = 0;

    // Compute the expected ALU outcome for one operation.
    function automatic fpalu_pkg::t_out alu_predict(fpalu_pkg::t_in op);
        fpalu_pkg::t_out r;
        logic signed [63:0] wide;
        logic signed [63:0] quot;
        longint lo_lim;
        longint hi_lim;
        r = '0;
        lo_lim = -(64'sd1 <<< (31 - FRAC));
        hi_lim = 64'sd2147483647 >>> FRAC;
        case (op.func)
            fpalu_pkg::FN_ADD: r.result = op.operand_a + op.operand_b;
            fpalu_pkg::FN_SUB: r.result = op.operand_a - op.operand_b;
            fpalu_pkg::FN_MUL: begin
                wide = 64'(op.operand_a) * 64'(op.operand_b);
                r.result = 32'(wide >>> FRAC);
            end
            fpalu_pkg::FN_DIV: begin
                if (op.operand_b == 0) begin
                    r.status = fpalu_pkg::ST_DIV0;
                end else begin
                    wide = 64'(op.operand_a) <<< FRAC;
                    quot = wide / 64'(op.operand_b);
                    r.result = 32'(quot);
                end
            end
            fpalu_pkg::FN_GT: r.flag = op.operand_a > op.operand_b;
            fpalu_pkg::FN_LT: r.flag = op.operand_a < op.operand_b;
            fpalu_pkg::FN_GE: r.flag = op.operand_a >= op.operand_b;
            fpalu_pkg::FN_LE: r.flag = op.operand_a <= op.operand_b;
            fpalu_pkg::FN_EQ: r.flag = op.operand_a == op.operand_b;
            fpalu_pkg::FN_NE: r.flag = op.operand_a != op.operand_b;
            fpalu_pkg::FN_MIN:
                r.result = (op.operand_a > op.operand_b) ? op.operand_b : op.operand_a;
            fpalu_pkg::FN_MAX:
                r.result = (op.operand_a < op.operand_b) ? op.operand_b : op.operand_a;
            fpalu_pkg::FN_FINT: begin
                if (longint'(op.operand_a) < lo_lim
                    || longint'(op.operand_a) > hi_lim)
                    r.status = fpalu_pkg::ST_RANGE;
                else
                    r.result = op.operand_a <<< FRAC;
            end
            fpalu_pkg::FN_TINT: r.result = op.operand_a >>> FRAC;
            fpalu_pkg::FN_INC: r.result = op.operand_a + 32'sd1;
            default: r.result = op.operand_a - 32'sd1;
        endcase
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Bias operands toward edges, small values and fixed-range borders.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 8) - 4;
            3: return 32'(($urandom_range(0, 2) - 1) + (32'sh7fff_ffff >>> FRAC));
            4: return 32'(($urandom_range(0, 2) - 1) - (32'sd1 <<< (31 - FRAC)));
            5: return $urandom_range(0, 4095) - 2048;
            default: return $urandom();
        endcase
    endfunction

    // Send one transaction; hold payload until the block takes it.
    // Valid drops only for a gap, so back-to-back sends keep it high.
    task automatic send_op(logic [3:0] fn, logic [31:0] a, logic [31:0] b, bit idle);
        int n;
        fpalu_pkg::t_in op;
        n = idle ? gap_len() : 0;
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        op.func = fn;
        op.operand_a = a;
        op.operand_b = b;
        i_data  <= op;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        alu_expected_q.push_back(alu_predict(op));
    endtask

    // Output side: random stall, compare every accepted transaction.
    bit stall_on = 1'b1;
    always @(posedge i_clk) begin
        fpalu_pkg::t_out exp_r;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (alu_expected_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result: %h", o_data);
                end else begin
                    exp_r = alu_expected_q.pop_front();
                    if (o_data.result !== exp_r.result || o_data.flag !== exp_r.flag
                        || o_data.status !== exp_r.status) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("mismatch: exp r=%h f=%b s=%0d  got r=%h f=%b s=%0d",
                                     exp_r.result, exp_r.flag, exp_r.status,
                                     o_data.result, o_data.flag, o_data.status);
                    end
                end
            end
            i_stall <= stall_on && ($urandom_range(0, 99) < 25);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("fixed_point_alu_unit regression: fail");
            $finish;
        end
    end

    // Every opcode at the operand extremes, then divide by zero, FINT range borders and other edge operands.
    task automatic test_directed_edges();
        for (int f = 0; f < 16; f++)
            send_op(4'(f), 32'h8000_0000, 32'h7fff_ffff, 1'b0);
        send_op(fpalu_pkg::FN_DIV, 32'h0000_0100, 32'h0, 1'b1);
        send_op(fpalu_pkg::FN_DIV, 32'h8000_0000, 32'hffff_ffff, 1'b1);
        send_op(fpalu_pkg::FN_EQ, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        send_op(fpalu_pkg::FN_FINT, 32'(32'sh7fff_ffff >>> FRAC), 32'h0, 1'b0);
        send_op(fpalu_pkg::FN_FINT, 32'((32'sh7fff_ffff >>> FRAC) + 1), 32'h0, 1'b0);
        send_op(fpalu_pkg::FN_FINT, 32'(-(32'sd1 <<< (31 - FRAC))), 32'h0, 1'b0);
        send_op(fpalu_pkg::FN_FINT, 32'(-(32'sd1 <<< (31 - FRAC)) - 1), 32'h0, 1'b1);
        send_op(fpalu_pkg::FN_TINT, 32'hffff_ff7f, 32'h0, 1'b0);
        send_op(fpalu_pkg::FN_MUL, 32'hffff_ffff, 32'h0000_0001, 1'b0);
    endtask

    // Random operations; input gaps only when idle is set, output stalls follow stall_on.
    task automatic test_random_ops(int count, bit idle);
        for (int i = 0; i < count; i++)
            send_op(4'($urandom_range(0, 15)), pick_operand(), pick_operand(), idle);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_edges();
        test_random_ops(1400, 1'b1);
        // Back-to-back stretch with the receiver never stalling.
        stall_on = 1'b0;
        test_random_ops(450, 1'b0);
        i_valid <= 1'b0;
        stall_on = 1'b1;
        while (alu_expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (mismatch_cnt == 0 && alu_expected_q.size() == 0)
            $display("fixed_point_alu_unit regression: pass");
        else
            $display("fixed_point_alu_unit regression: fail");
        $finish;
    end

endmodule
